@@ rtl/core/ssds_pkg.sv @@
package ssds_pkg;

    localparam int unsigned SAMPLE_CYCLES = 4;
    localparam int unsigned BYTE_BITS     = 8;
    localparam int unsigned WAIT_W        = 3;

    typedef struct packed {
        logic        cpu_runs;
        logic        oam_write_valid;
        logic [7:0]  oam_write_index;
        logic [7:0]  oam_write_data;
        logic        dmc_sample_valid;
        logic [7:0]  dmc_sample;
        logic [15:0] next_read_address;
    } t_result;

endpackage

@@ rtl/core/sprite_and_sample_dma_sequencer_core.sv @@
// Channel | Dir | Handshake                 | Fields
// --------+-----+---------------------------+------------------------------------------------
// input   | in  | i_in_valid / o_in_stall   | i_bus_data, i_oam_request/page_in, i_dmc_*
// output  | out | o_out_valid / i_out_stall | o_cpu_runs, o_oam_write_*, o_dmc_*, o_next_read_*
//
// One transfer in per cycle while o_in_stall is low: the state update and the result are one
// short level of logic. A result register plus a skid register sit on the output; a result is
// registered at its transfer edge, into the result register or, while that is held, into the
// skid register. An item is taken whenever the skid register is empty.
// Reset (i_rst_n low, synchronous) clears all DMA state, parity and both valid flags.
// o_in_stall is a register output and rises only when both output entries are full.
module sprite_and_sample_dma_sequencer_core
    import ssds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_bus_data,
    input  logic        i_oam_request,
    input  logic [7:0]  i_oam_page_in,
    input  logic        i_dmc_request,
    input  logic [15:0] i_dmc_address_in,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_cpu_runs,
    output logic        o_oam_write_valid,
    output logic [7:0]  o_oam_write_index,
    output logic [7:0]  o_oam_write_data,
    output logic        o_dmc_sample_valid,
    output logic [7:0]  o_dmc_sample,
    output logic [15:0] o_next_read_address
);

    // DMA sequencing state
    logic              r_cycle_parity,    n_cycle_parity;
    logic              r_sprite_pending,  n_sprite_pending;
    logic              r_sprite_active,   n_sprite_active;
    logic [7:0]        r_sprite_page,     n_sprite_page;
    logic [7:0]        r_sprite_offset,   n_sprite_offset;
    logic [7:0]        r_sprite_byte,     n_sprite_byte;
    logic              r_sample_pending,  n_sample_pending;
    logic              r_sample_active,   n_sample_active;
    logic [15:0]       r_sample_address,  n_sample_address;
    logic [WAIT_W-1:0] r_sample_wait,     n_sample_wait;

    // Output register and skid register
    t_result r_out, r_skid, n_result;
    logic    r_out_valid, r_skid_valid;

    logic in_fire;
    logic out_fire;

    assign in_fire  = i_in_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_out_stall;

    // Next state and result for the item being transferred in this cycle.
    always_comb begin
        n_cycle_parity   = r_cycle_parity;
        n_sprite_pending = r_sprite_pending;
        n_sprite_active  = r_sprite_active;
        n_sprite_page    = r_sprite_page;
        n_sprite_offset  = r_sprite_offset;
        n_sprite_byte    = r_sprite_byte;
        n_sample_pending = r_sample_pending;
        n_sample_active  = r_sample_active;
        n_sample_address = r_sample_address;
        n_sample_wait    = r_sample_wait;
        n_result         = '0;

        if (r_sprite_pending) begin
            // Sprite DMA owns the bus; sample DMA pauses with its count intact.
            if (!r_sprite_active && !r_cycle_parity) begin
                n_sprite_active = 1'b1;
            end
            if (n_sprite_active) begin
                if (!r_cycle_parity) begin
                    // Even cycle: latch the byte read from page:offset.
                    n_sprite_byte = i_bus_data;
                end else begin
                    // Odd cycle: write it and advance; wrap of offset ends the transfer.
                    n_result.oam_write_valid = 1'b1;
                    n_result.oam_write_index = r_sprite_offset;
                    n_result.oam_write_data  = r_sprite_byte;
                    n_sprite_offset          = r_sprite_offset + 8'd1;
                    if (n_sprite_offset == 8'd0) begin
                        n_sprite_pending = 1'b0;
                        n_sprite_active  = 1'b0;
                    end
                end
            end
        end else if (r_sample_pending) begin
            // Count stall cycles in the wait register, then read once it reaches SAMPLE_CYCLES.
            n_sample_active = 1'b1;
            n_sample_wait   = (r_sample_active ? r_sample_wait : '0) + WAIT_W'(1);
            if (n_sample_wait >= WAIT_W'(SAMPLE_CYCLES)) begin
                n_result.dmc_sample_valid = 1'b1;
                n_result.dmc_sample       = i_bus_data;
                n_sample_pending          = 1'b0;
                n_sample_active           = 1'b0;
                n_sample_wait             = '0;
            end
        end else begin
            n_result.cpu_runs = 1'b1;
        end

        // Requests take effect from the next cycle.
        if (i_oam_request) begin
            n_sprite_pending = 1'b1;
            n_sprite_page    = i_oam_page_in;
        end
        if (i_dmc_request) begin
            n_sample_pending = 1'b1;
            n_sample_address = i_dmc_address_in;
        end

        n_cycle_parity = !r_cycle_parity;

        // Announce the read of the next cycle.
        if (n_sprite_pending) begin
            if (!n_cycle_parity) begin
                n_result.next_read_address = {n_sprite_page, n_sprite_offset};
            end
        end else if (n_sample_pending && n_sample_active &&
                     n_sample_wait == WAIT_W'(SAMPLE_CYCLES - 1)) begin
            n_result.next_read_address = n_sample_address;
        end
    end

    // Advance state on each transfer in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_parity   <= 1'b0;
            r_sprite_pending <= 1'b0;
            r_sprite_active  <= 1'b0;
            r_sprite_page    <= '0;
            r_sprite_offset  <= '0;
            r_sprite_byte    <= '0;
            r_sample_pending <= 1'b0;
            r_sample_active  <= 1'b0;
            r_sample_address <= '0;
            r_sample_wait    <= '0;
        end else if (in_fire) begin
            r_cycle_parity   <= n_cycle_parity;
            r_sprite_pending <= n_sprite_pending;
            r_sprite_active  <= n_sprite_active;
            r_sprite_page    <= n_sprite_page;
            r_sprite_offset  <= n_sprite_offset;
            r_sprite_byte    <= n_sprite_byte;
            r_sample_pending <= n_sample_pending;
            r_sample_active  <= n_sample_active;
            r_sample_address <= n_sample_address;
            r_sample_wait    <= n_sample_wait;
        end
    end

    // Output register with skid: refill from skid first, else from the new result;
    // park the new result in skid while the output register is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= n_result;
            end
        end else if (in_fire) begin
            r_skid <= n_result;
        end
    end

    assign o_in_stall          = r_skid_valid;
    assign o_out_valid         = r_out_valid;
    assign o_cpu_runs          = r_out.cpu_runs;
    assign o_oam_write_valid   = r_out.oam_write_valid;
    assign o_oam_write_index   = r_out.oam_write_index;
    assign o_oam_write_data    = r_out.oam_write_data;
    assign o_dmc_sample_valid  = r_out.dmc_sample_valid;
    assign o_dmc_sample        = r_out.dmc_sample;
    assign o_next_read_address = r_out.next_read_address;

    // A DMA action always stalls the processor, and only one DMA owns a cycle.
    a_write_stalls_cpu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.oam_write_valid || r_out.dmc_sample_valid) |->
            !r_out.cpu_runs && !(r_out.oam_write_valid && r_out.dmc_sample_valid))
        else $error("DMA action reported with processor running or both DMAs active");

    // The skid register is only occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // Every transfer in flips the cycle parity.
    a_parity_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_cycle_parity != $past(r_cycle_parity))
        else $error("cycle parity did not toggle on a transfer");

    // A sample wait count only runs while a sample transfer is active.
    a_wait_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sample_active |-> r_sample_wait == '0 || r_sprite_pending || !r_sample_pending)
        else $error("sample wait count nonzero without an active sample transfer");

endmodule

@@ tb/sprite_and_sample_dma_sequencer_core_test.sv @@
module sprite_and_sample_dma_sequencer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssds_pkg::*;

    // One processor cycle as offered to the sequencer.
    typedef struct packed {
        logic [7:0]  bus_data;
        logic        oam_req;
        logic [7:0]  oam_page;
        logic        dmc_req;
        logic [15:0] dmc_addr;
    } t_dma_cycle;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned RANDOM_CYCLES = 400;
    localparam int unsigned DRAIN_AT      = 200;   // sender pauses here until all results land
    localparam int unsigned HOLD_FROM     = 500;   // receiver blocks for a long stretch here
    localparam int unsigned HOLD_LEN      = 80;
    localparam int unsigned QUIET_FROM    = 300;   // no idling on either side in this window
    localparam int unsigned QUIET_TO      = 450;
    localparam int unsigned IDLE_PCT      = 13;
    localparam int unsigned TAIL_CYCLES   = 20;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;

    // Stimulus side of the block.
    logic        in_valid  = 1'b0;
    logic [7:0]  bus_data  = '0;
    logic        oam_req   = 1'b0;
    logic [7:0]  oam_page  = '0;
    logic        dmc_req   = 1'b0;
    logic [15:0] dmc_addr  = '0;
    logic        out_stall = 1'b0;

    // Block outputs.
    logic        in_stall;
    logic        out_valid;
    logic        cpu_runs;
    logic        oam_wr_valid;
    logic [7:0]  oam_wr_index;
    logic [7:0]  oam_wr_data;
    logic        smp_valid;
    logic [7:0]  smp_byte;
    logic [15:0] next_addr;

    t_dma_cycle  cycle_q[$];         // cycles waiting to be offered
    t_result     expected_q[$];      // predicted per-cycle decisions, oldest first

    int unsigned cyc        = 0;
    int unsigned n_accepted = 0;
    int unsigned n_err      = 0;
    bit          in_took    = 1'b0;  // the cycle on the bus was transferred at the last edge
    bit          drain_done = 1'b0;

    // Sequencer state as the predictor sees it.
    logic              par;
    logic              spr_pend;
    logic              spr_act;
    logic [7:0]        spr_page;
    logic [7:0]        spr_ofs;
    logic [7:0]        spr_latch;
    logic              smp_pend;
    logic              smp_act;
    logic [15:0]       smp_addr;
    logic [WAIT_W-1:0] smp_count;

    sprite_and_sample_dma_sequencer_core u_top (
        .i_clk               (i_clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_bus_data          (bus_data),
        .i_oam_request       (oam_req),
        .i_oam_page_in       (oam_page),
        .i_dmc_request       (dmc_req),
        .i_dmc_address_in    (dmc_addr),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_cpu_runs          (cpu_runs),
        .o_oam_write_valid   (oam_wr_valid),
        .o_oam_write_index   (oam_wr_index),
        .o_oam_write_data    (oam_wr_data),
        .o_dmc_sample_valid  (smp_valid),
        .o_dmc_sample        (smp_byte),
        .o_next_read_address (next_addr)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advance the sequencer by one processor cycle and return its decision.
    function automatic t_result predict_dma_cycle(t_dma_cycle c);
        t_result r;
        r = '0;
        if (spr_pend) begin
            // Sprite DMA owns the bus; it only starts on an even cycle.
            if (!spr_act && !par)
                spr_act = 1'b1;
            if (spr_act) begin
                if (!par) begin
                    spr_latch = c.bus_data;
                end else begin
                    r.oam_write_valid = 1'b1;
                    r.oam_write_index = spr_ofs;
                    r.oam_write_data  = spr_latch;
                    spr_ofs = spr_ofs + 8'd1;
                    if (spr_ofs == 8'd0) begin
                        spr_pend = 1'b0;
                        spr_act  = 1'b0;
                    end
                end
            end
        end else if (smp_pend) begin
            // Sample DMA: stall until the count reaches SAMPLE_CYCLES, then read and deliver.
            if (!smp_act) begin
                smp_act   = 1'b1;
                smp_count = '0;
            end
            smp_count = smp_count + 1'b1;
            if (smp_count >= SAMPLE_CYCLES) begin
                r.dmc_sample_valid = 1'b1;
                r.dmc_sample       = c.bus_data;
                smp_pend  = 1'b0;
                smp_act   = 1'b0;
                smp_count = '0;
            end
        end else begin
            r.cpu_runs = 1'b1;
        end

        // Requests in this cycle only count from the next one.
        if (c.oam_req) begin
            spr_pend = 1'b1;
            spr_page = c.oam_page;
        end
        if (c.dmc_req) begin
            smp_pend = 1'b1;
            smp_addr = c.dmc_addr;
        end
        par = ~par;

        // Announce the address the next cycle will read, if any.
        if (spr_pend) begin
            if (!par)
                r.next_read_address = {spr_page, spr_ofs};
        end else if (smp_pend && smp_act && smp_count == SAMPLE_CYCLES - 1) begin
            r.next_read_address = smp_addr;
        end
        return r;
    endfunction

    task automatic queue_cycle(logic [7:0] data, logic oreq, logic [7:0] page,
                               logic dreq, logic [15:0] addr);
        t_dma_cycle c;
        c.bus_data = data;
        c.oam_req  = oreq;
        c.oam_page = page;
        c.dmc_req  = dreq;
        c.dmc_addr = addr;
        cycle_q.push_back(c);
    endtask

    // Random cycle; a request fires about once in the given number of cycles.
    function automatic t_dma_cycle random_cycle(int unsigned oam_odds, int unsigned dmc_odds);
        t_dma_cycle c;
        c.bus_data = 8'($urandom);
        c.oam_req  = ($urandom_range(oam_odds - 1) == 0);
        c.oam_page = 8'($urandom);
        c.dmc_req  = ($urandom_range(dmc_odds - 1) == 0);
        c.dmc_addr = 16'($urandom);
        return c;
    endfunction

    task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
            n_err++;
        end
    endtask

    // Stimulus, reset and end of run.
    initial begin
        int unsigned n_rand;
        int unsigned n_sprite;
        int unsigned kind;
        int unsigned len;

        par = 1'b0; spr_pend = 1'b0; spr_act = 1'b0; spr_page = '0; spr_ofs = '0;
        spr_latch = '0; smp_pend = 1'b0; smp_act = 1'b0; smp_addr = '0; smp_count = '0;

        // Directed: plain run, sample fetch at the top address, address replaced
        // mid-fetch, extreme bus bytes, both requests together, sprite page replaced.
        queue_cycle(8'hFF, 1'b0, 8'h00, 1'b0, 16'h0000);
        queue_cycle(8'h00, 1'b0, 8'h00, 1'b1, 16'hFFFF);
        queue_cycle(8'h3C, 1'b0, 8'h00, 1'b0, 16'h0000);
        queue_cycle(8'hC3, 1'b0, 8'h00, 1'b1, 16'h0000);
        queue_cycle(8'h00, 1'b0, 8'h00, 1'b0, 16'h0000);
        queue_cycle(8'hFF, 1'b0, 8'h00, 1'b0, 16'h0000);
        queue_cycle(8'h5A, 1'b0, 8'h00, 1'b0, 16'h0000);
        queue_cycle(8'h11, 1'b1, 8'hFF, 1'b1, 16'h8001);
        for (int i = 0; i < 8; i++)
            queue_cycle((i % 2) ? 8'h00 : 8'hFF, 1'b0, 8'h00, 1'b0, 16'h0000);
        queue_cycle(8'h44, 1'b1, 8'h00, 1'b0, 16'h0000);
        for (int i = 0; i < 6; i++)
            queue_cycle(8'($urandom), 1'b0, 8'h00, 1'b0, 16'h0000);

        // Random: mostly well-formed DMA episodes with random content, plus noise.
        // Keep going until at least one sprite transfer has run all 256 offsets.
        n_rand   = 0;
        n_sprite = 0;
        while (n_rand < RANDOM_CYCLES || n_sprite == 0) begin
            kind = $urandom_range(99);
            if ((kind < 8 && n_sprite < 3) || (n_rand >= RANDOM_CYCLES && n_sprite == 0)) begin
                // Full sprite transfer; sample requests and page rewrites ride along.
                queue_cycle(8'($urandom), 1'b1, 8'($urandom), 1'b0, 16'($urandom));
                len = $urandom_range(530, 515);
                for (int i = 0; i < len; i++)
                    cycle_q.push_back(random_cycle(300, 40));
                n_sprite++;
                n_rand += len + 1;
            end else if (kind < 60) begin
                // Sample fetch, sometimes with the address replaced while waiting.
                queue_cycle(8'($urandom), 1'b0, 8'($urandom), 1'b1, 16'($urandom));
                len = $urandom_range(7, 2);
                for (int i = 0; i < len; i++)
                    cycle_q.push_back(random_cycle(1000, 10));
                n_rand += len + 1;
            end else begin
                len = $urandom_range(4, 1);
                for (int i = 0; i < len; i++)
                    cycle_q.push_back(random_cycle(50, 2));
                n_rand += len;
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Wait for the last cycle to be transferred, then for its result.
        while (cycle_q.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_err == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Sender: offer the next cycle once the current one is transferred.
    always @(negedge i_clk) begin
        bit hold;
        bit quiet;
        if (rst_n) begin
            quiet = (cyc >= QUIET_FROM && cyc < QUIET_TO);
            // Pause once until every predicted result has come back.
            if (!drain_done && n_accepted >= DRAIN_AT && expected_q.size() == 0)
                drain_done = 1'b1;
            hold = (!drain_done && n_accepted >= DRAIN_AT);
            if (!in_valid || in_took) begin
                if (cycle_q.size() != 0 && !hold &&
                    (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    t_dma_cycle c;
                    c = cycle_q.pop_front();
                    bus_data <= c.bus_data;
                    oam_req  <= c.oam_req;
                    oam_page <= c.oam_page;
                    dmc_req  <= c.dmc_req;
                    dmc_addr <= c.dmc_addr;
                    in_valid <= 1'b1;
                end else begin
                    // Idle: scramble the payload, the block must ignore it.
                    bus_data <= 8'($urandom);
                    oam_req  <= 1'($urandom);
                    oam_page <= 8'($urandom);
                    dmc_req  <= 1'($urandom);
                    dmc_addr <= 16'($urandom);
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and a quiet window.
    always @(negedge i_clk) begin
        int unsigned rx_cycles;
        if (rst_n) begin
            rx_cycles++;
            if (rx_cycles >= HOLD_FROM && rx_cycles < HOLD_FROM + HOLD_LEN)
                out_stall <= 1'b1;
            else if (cyc >= QUIET_FROM && cyc < QUIET_TO)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Edge monitor: check transferred results, predict transferred cycles.
    always @(posedge i_clk) begin
        t_result exp_res;
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no cycle outstanding");
                    n_err++;
                end else begin
                    exp_res = expected_q.pop_front();
                    check_field("cpu_runs", 16'(exp_res.cpu_runs), 16'(cpu_runs));
                    check_field("oam_write_valid", 16'(exp_res.oam_write_valid),
                                16'(oam_wr_valid));
                    check_field("oam_write_index", 16'(exp_res.oam_write_index),
                                16'(oam_wr_index));
                    check_field("oam_write_data", 16'(exp_res.oam_write_data),
                                16'(oam_wr_data));
                    check_field("dmc_sample_valid", 16'(exp_res.dmc_sample_valid),
                                16'(smp_valid));
                    check_field("dmc_sample", 16'(exp_res.dmc_sample), 16'(smp_byte));
                    check_field("next_read_address", exp_res.next_read_address, next_addr);
                end
            end
            in_took = in_valid && !in_stall;
            if (in_took) begin
                t_dma_cycle c;
                c.bus_data = bus_data;
                c.oam_req  = oam_req;
                c.oam_page = oam_page;
                c.dmc_req  = dmc_req;
                c.dmc_addr = dmc_addr;
                expected_q.push_back(predict_dma_cycle(c));
                n_accepted++;
            end
        end
    end

endmodule
